### src/sba_pkg.sv
// Shared types, constants and helpers for the segmented block allocator.
// No dependencies; used by every file under src.
package sba_pkg;

    localparam int HANDLE_W         = 12;
    localparam int SLOT_W           = HANDLE_W + 1;
    localparam int STACK_DEPTH      = 4080;
    localparam int SEG_W            = 3;
    localparam int OFF_W            = 11;
    localparam int BBYTES_W         = 16;
    localparam int BOFF_W           = OFF_W + BBYTES_W;
    localparam int STATUS_W         = 2;
    localparam int LOG_W            = 4;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 16;
    localparam int BASE_LOG2_DEF    = 4;
    localparam int MAX_SEGMENTS_DEF = 8;

    localparam logic [HANDLE_W-1:0] MAX_BLOCKS_RST  = 12'd4080;
    localparam logic [BBYTES_W-1:0] BLOCK_BYTES_RST = 16'd64;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_EXHAUSTED  = 2'd1,
        STAT_STACK_FULL = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BLOCKS  = 2'd0,
        CFG_UNLIMITED   = 2'd1,
        CFG_BLOCK_BYTES = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GROW,
        ST_READ,
        ST_DECODE,
        ST_MUL,
        ST_FREE,
        ST_FIN
    } state_t;

    // handshake between sequencer and shift-add multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

    // position of the highest set bit (zero for zero)
    function automatic logic [LOG_W-1:0] floor_log2(input logic [HANDLE_W:0] v);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i <= HANDLE_W; i++)
        begin
            if (v[i])
            begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### src/segmented_block_allocator.sv
// Allocate runs read, decode and the 11-step shift-add multiplier, after a growth step when a segment
// is added; free and refused allocate go to the result straight after the free or growth step.
// Throughput: one request at a time; a new request is taken once the result is parked
// in the output register, even while that result is still stalled.
// Reset (rst_n, async, active low) resets control state and configuration;
// slots below the low mark (lowest slot popped since the last growth) read as empty.
module segmented_block_allocator #(
    parameter int BASE_LOG2    = sba_pkg::BASE_LOG2_DEF,
    parameter int MAX_SEGMENTS = sba_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                opcode,
    input  logic [sba_pkg::HANDLE_W-1:0]        handle_in,
    // result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [sba_pkg::STATUS_W-1:0]        status,
    output logic [sba_pkg::HANDLE_W-1:0]        handle_out,
    output logic [sba_pkg::SEG_W-1:0]           segment,
    output logic [sba_pkg::OFF_W-1:0]           offset_in_segment,
    output logic [sba_pkg::BOFF_W-1:0]          byte_offset,
    output logic [sba_pkg::HANDLE_W-1:0]        blocks_in_use,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [sba_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sba_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int HW      = sba_pkg::HANDLE_W;
    localparam int SEGC_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int EXP_W   = $clog2(MAX_SEGMENTS + BASE_LOG2 + 1);
    localparam int START_W = HW + 1 + BASE_LOG2;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [HW-1:0]                  max_blocks_reg;
    logic                           unlimited_reg;
    logic [sba_pkg::BBYTES_W-1:0]   block_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_blocks_reg  <= sba_pkg::MAX_BLOCKS_RST;
            unlimited_reg   <= 1'b1;
            block_bytes_reg <= sba_pkg::BLOCK_BYTES_RST;
        end
        else if (cfg_we)
        begin
            case (sba_pkg::cfg_idx_t'(cfg_index))
                sba_pkg::CFG_MAX_BLOCKS:  max_blocks_reg  <= cfg_wdata[HW-1:0];
                sba_pkg::CFG_UNLIMITED:   unlimited_reg   <= cfg_wdata[0];
                sba_pkg::CFG_BLOCK_BYTES: block_bytes_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Pool state
    // ---------------------------------------------------------------------
    sba_pkg::state_t            state_reg, state_next;
    logic [SEGC_W-1:0]          seg_made_reg;
    logic [HW-1:0]              total_reg;
    logic [HW-1:0]              free_cnt_reg;
    logic [HW-1:0]              in_use_reg;
    logic [HW-1:0]              low_mark_reg;     // slots below were not written since growth
    logic [HW-1:0]              hin_reg;

    // result being built, then the output register
    logic [sba_pkg::STATUS_W-1:0]   res_status_reg;
    logic [HW-1:0]                  res_handle_reg;
    logic [sba_pkg::SEG_W-1:0]      res_seg_reg;
    logic [sba_pkg::OFF_W-1:0]      res_off_reg;
    logic [sba_pkg::BOFF_W-1:0]     res_bytes_reg;

    logic                           out_valid_reg;
    logic [sba_pkg::STATUS_W-1:0]   out_status_reg;
    logic [HW-1:0]                  out_handle_reg;
    logic [sba_pkg::SEG_W-1:0]      out_seg_reg;
    logic [sba_pkg::OFF_W-1:0]      out_off_reg;
    logic [sba_pkg::BOFF_W-1:0]     out_bytes_reg;
    logic [HW-1:0]                  out_in_use_reg;

    // ---------------------------------------------------------------------
    // Growth size: (1 << segments_made) << BASE_LOG2, clipped to both limits
    // ---------------------------------------------------------------------
    logic [EXP_W-1:0]   grow_exp;
    logic [HW:0]        grow_raw;
    logic [HW:0]        room_limit;
    logic [HW:0]        room_store;
    logic [HW:0]        grow_n;
    logic               grow_ok;

    always_comb
    begin
        grow_exp = EXP_W'(seg_made_reg) + EXP_W'(BASE_LOG2);
        if (grow_exp > EXP_W'(HW))
        begin
            grow_raw = '1;
        end
        else
        begin
            grow_raw = (HW + 1)'(1) << grow_exp;
        end

        if (unlimited_reg)
        begin
            room_limit = '1;
        end
        else if (max_blocks_reg > total_reg)
        begin
            room_limit = (HW + 1)'(max_blocks_reg - total_reg);
        end
        else
        begin
            room_limit = '0;
        end

        room_store = (HW + 1)'(sba_pkg::STACK_DEPTH) - (HW + 1)'(total_reg);

        grow_n = grow_raw;
        if (room_limit < grow_n)
        begin
            grow_n = room_limit;
        end
        if (room_store < grow_n)
        begin
            grow_n = room_store;
        end

        grow_ok = (seg_made_reg < SEGC_W'(MAX_SEGMENTS)) && (grow_n != '0);
    end

    // ---------------------------------------------------------------------
    // Stack access and slot decode
    // ---------------------------------------------------------------------
    logic [HW-1:0]                  top_idx;
    logic [sba_pkg::SLOT_W-1:0]     slot_rd;
    logic                           slot_bound;
    logic [HW-1:0]                  alloc_h;
    logic [HW:0]                    seg_arg;
    logic [sba_pkg::LOG_W-1:0]      seg_log;
    logic [START_W-1:0]             seg_start;
    logic [START_W-1:0]             seg_pos;
    logic                           free_ok;

    assign top_idx = free_cnt_reg - HW'(1);
    assign free_ok = free_cnt_reg < total_reg;

    always_comb
    begin
        // a slot only holds a handle if it was written since the last growth
        slot_bound = slot_rd[HW] && (top_idx >= low_mark_reg);
        alloc_h    = slot_bound ? slot_rd[HW-1:0] : in_use_reg;
        // segment k starts at ((1 << k) - 1) << BASE_LOG2
        seg_arg    = ((HW + 1)'(alloc_h) >> BASE_LOG2) + (HW + 1)'(1);
        seg_log    = sba_pkg::floor_log2(seg_arg);
        seg_start  = ((START_W'(1) << seg_log) - START_W'(1)) << BASE_LOG2;
        seg_pos    = START_W'(alloc_h) - seg_start;
    end

    logic                       mem_wr_en;
    logic [HW-1:0]              mem_wr_addr;
    logic [sba_pkg::SLOT_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic                       mul_start;
    logic                       out_load;
    sba_pkg::mul_status_t       mul_stat;
    logic [sba_pkg::BOFF_W-1:0] mul_product;

    sba_stack_mem u_stack (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (top_idx),
        .rd_data (slot_rd)
    );

    sba_mul_unit u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mplier  (seg_pos[sba_pkg::OFF_W-1:0]),
        .mcand   (block_bytes_reg),
        .stat    (mul_stat),
        .product (mul_product)
    );

    // ---------------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == sba_pkg::OP_FREE)
                    begin
                        state_next = sba_pkg::ST_FREE;
                    end
                    else if (free_cnt_reg == '0)
                    begin
                        state_next = sba_pkg::ST_GROW;
                    end
                    else
                    begin
                        state_next = sba_pkg::ST_READ;
                    end
                end
            end
            sba_pkg::ST_GROW:   state_next = grow_ok ? sba_pkg::ST_READ : sba_pkg::ST_FIN;
            sba_pkg::ST_READ:   state_next = sba_pkg::ST_DECODE;
            sba_pkg::ST_DECODE: state_next = sba_pkg::ST_MUL;
            sba_pkg::ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = sba_pkg::ST_FIN;
                end
            end
            sba_pkg::ST_FREE:   state_next = sba_pkg::ST_FIN;
            sba_pkg::ST_FIN:
            begin
                if (out_load)
                begin
                    state_next = sba_pkg::ST_IDLE;
                end
            end
            default:            state_next = sba_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------------
    always_comb
    begin
        in_stall    = 1'b1;
        mem_rd_en   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = top_idx;
        mem_wr_data = '0;
        mul_start   = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            sba_pkg::ST_IDLE:   in_stall  = 1'b0;
            sba_pkg::ST_READ:   mem_rd_en = 1'b1;
            sba_pkg::ST_DECODE:
            begin
                // popped slot goes back to empty
                mem_wr_en = 1'b1;
                mul_start = 1'b1;
            end
            sba_pkg::ST_FREE:
            begin
                mem_wr_en   = free_ok;
                mem_wr_addr = free_cnt_reg;
                mem_wr_data = {1'b1, hin_reg};
            end
            sba_pkg::ST_FIN:    out_load = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // State and pool counters
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sba_pkg::ST_IDLE;
            seg_made_reg <= '0;
            total_reg    <= '0;
            free_cnt_reg <= '0;
            in_use_reg   <= '0;
            low_mark_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                sba_pkg::ST_GROW:
                begin
                    if (grow_ok)
                    begin
                        seg_made_reg <= seg_made_reg + SEGC_W'(1);
                        total_reg    <= total_reg + grow_n[HW-1:0];
                        free_cnt_reg <= free_cnt_reg + grow_n[HW-1:0];
                        // the whole stack is logically empty here
                        low_mark_reg <= free_cnt_reg + grow_n[HW-1:0];
                    end
                end
                sba_pkg::ST_DECODE:
                begin
                    free_cnt_reg <= top_idx;
                    in_use_reg   <= in_use_reg + HW'(1);
                    if (top_idx < low_mark_reg)
                    begin
                        low_mark_reg <= top_idx;
                    end
                end
                sba_pkg::ST_FREE:
                begin
                    if (free_ok)
                    begin
                        free_cnt_reg <= free_cnt_reg + HW'(1);
                        if (in_use_reg != '0)
                        begin
                            in_use_reg <= in_use_reg - HW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // request capture and result fields
    always_ff @(posedge clk)
    begin
        case (state_reg)
            sba_pkg::ST_IDLE:
            begin
                hin_reg        <= handle_in;
                res_status_reg <= sba_pkg::STAT_OK;
                res_handle_reg <= '0;
                res_seg_reg    <= '0;
                res_off_reg    <= '0;
                res_bytes_reg  <= '0;
            end
            sba_pkg::ST_GROW:
            begin
                if (!grow_ok)
                begin
                    res_status_reg <= sba_pkg::STAT_EXHAUSTED;
                end
            end
            sba_pkg::ST_DECODE:
            begin
                res_handle_reg <= alloc_h;
                res_seg_reg    <= seg_log[sba_pkg::SEG_W-1:0];
                res_off_reg    <= seg_pos[sba_pkg::OFF_W-1:0];
            end
            sba_pkg::ST_MUL:
            begin
                if (mul_stat.done)
                begin
                    res_bytes_reg <= mul_product;
                end
            end
            sba_pkg::ST_FREE:
            begin
                if (!free_ok)
                begin
                    res_status_reg <= sba_pkg::STAT_STACK_FULL;
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_handle_reg <= res_handle_reg;
            out_seg_reg    <= res_seg_reg;
            out_off_reg    <= res_off_reg;
            out_bytes_reg  <= res_bytes_reg;
            out_in_use_reg <= in_use_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign handle_out        = out_handle_reg;
    assign segment           = out_seg_reg;
    assign offset_in_segment = out_off_reg;
    assign byte_offset       = out_bytes_reg;
    assign blocks_in_use     = out_in_use_reg;

endmodule

### src/sba_stack_mem.sv
// Free stack storage: one write port, one registered read port.
// Depends on sba_pkg for slot width and depth.
module sba_stack_mem (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [sba_pkg::HANDLE_W-1:0]            wr_addr,
    input  logic [sba_pkg::SLOT_W-1:0]              wr_data,
    input  logic                                    rd_en,
    input  logic [sba_pkg::HANDLE_W-1:0]            rd_addr,
    output logic [sba_pkg::SLOT_W-1:0]              rd_data
);

    logic [sba_pkg::SLOT_W-1:0] mem_reg [sba_pkg::STACK_DEPTH];
    logic [sba_pkg::SLOT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/sba_mul_unit.sv
// Shift-add multiplier: one adder stepped once per multiplier bit.
// Depends on sba_pkg for operand and product widths.
module sba_mul_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sba_pkg::OFF_W-1:0]       mplier,
    input  logic [sba_pkg::BBYTES_W-1:0]    mcand,
    output sba_pkg::mul_status_t            stat,
    output logic [sba_pkg::BOFF_W-1:0]      product
);

    localparam int CNT_W = $clog2(sba_pkg::OFF_W);

    logic                           busy_reg;
    logic                           done_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic [sba_pkg::BOFF_W-1:0]     acc_reg;
    logic [sba_pkg::BOFF_W-1:0]     mcand_reg;
    logic [sba_pkg::OFF_W-1:0]      mplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(sba_pkg::OFF_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= sba_pkg::BOFF_W'(mcand);
            mplier_reg <= mplier;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

### src/sba_checker.sv
// Port-level checks for segmented_block_allocator, bound to the top level.
// Depends on sba_pkg for widths and status codes.
module sba_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [sba_pkg::STATUS_W-1:0]         status,
    input logic [sba_pkg::HANDLE_W-1:0]         handle_out,
    input logic [sba_pkg::SEG_W-1:0]            segment,
    input logic [sba_pkg::OFF_W-1:0]            offset_in_segment,
    input logic [sba_pkg::BOFF_W-1:0]           byte_offset
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(handle_out) && $stable(status))
        else $error("result changed while stalled");

    // a request keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request taken on consecutive cycles");

    // failures carry no block
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != sba_pkg::STAT_OK) |->
            handle_out == '0 && segment == '0 && offset_in_segment == '0
            && byte_offset == '0)
        else $error("failed request reported a block");

    // segment zero starts at block zero
    a_seg0_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (segment == '0) |->
            offset_in_segment == handle_out[sba_pkg::OFF_W-1:0])
        else $error("segment zero offset mismatch");

endmodule

bind segmented_block_allocator sba_checker u_sba_checker (.*);
